[sv/tblm_pkg.sv]
// Package for the three-band level meter: constants, shared types and Q15 helpers.
package tblm_pkg;

    localparam int SAMPLE_BITS          = 16;
    localparam int SAMPLE_W             = 16;
    localparam int MAX_BLOCK_FRAMES_DEF = 4096;
    localparam int STATE_W              = 18;
    localparam int COEF_W               = 17;
    localparam int SUM_W                = 32;
    localparam int LEVEL_W              = 16;
    localparam int BAND_W               = 2;
    localparam int DIV_W                = SUM_W + 1;
    localparam int QUEUE_DEPTH          = 2;
    localparam int CFG_ADDR_W           = 3;
    localparam int CFG_DATA_W           = 32;

    localparam int FULL_SCALE_RAW = 1 << (SAMPLE_BITS - 1);
    localparam logic [LEVEL_W-1:0] FULL_SCALE =
        LEVEL_W'((FULL_SCALE_RAW > 65535) ? 65535 : FULL_SCALE_RAW);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam logic [CFG_ADDR_W-3:0] REG_CHANNEL_MODE = '0;

    localparam logic signed [COEF_W-1:0] C_BASS_FB = 17'sd31130;
    localparam logic signed [COEF_W-1:0] C_BASS_IN = 17'sd1638;
    localparam logic signed [COEF_W-1:0] C_MID_FB  = 17'sd26214;
    localparam logic signed [COEF_W-1:0] C_MID_IN  = 17'sd6554;
    localparam logic signed [COEF_W-1:0] C_HP_MID  = 17'sd22938;
    localparam logic signed [COEF_W-1:0] C_HIGH_FB = 17'sd9830;
    localparam logic signed [COEF_W-1:0] C_HIGH_IN = 17'sd22938;

    localparam logic [BAND_W-1:0] BAND_BASS = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic                       last;
    } frame_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Q15 product, rounded half up (floor of (a*c + 2^14) / 2^15)
    function automatic logic signed [STATE_W-1:0] mul_q15(
        input logic signed [STATE_W-1:0] a,
        input logic signed [COEF_W-1:0]  c
    );
        logic signed [STATE_W+COEF_W-1:0] p;
        p = a * c;
        p = p + 35'sd16384;
        return p[STATE_W+14:15];
    endfunction

    function automatic logic [STATE_W-1:0] abs_st(input logic signed [STATE_W-1:0] a);
        return a[STATE_W-1] ? STATE_W'(-a) : STATE_W'(a);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0]   s,
        input logic [STATE_W-1:0] a
    );
        logic [SUM_W:0] r;
        r = {1'b0, s} + (SUM_W+1)'(a);
        return r[SUM_W] ? '1 : r[SUM_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(
        input logic [DIV_W-1:0]   q,
        input logic [LEVEL_W-1:0] cap
    );
        return (q > DIV_W'(cap)) ? cap : q[LEVEL_W-1:0];
    endfunction

endpackage

[sv/tblm_frame_if.sv]
// Frame channel: valid/ready with the left and right samples and the block end mark.
interface tblm_frame_if
    import tblm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_end;

    modport source (output valid, left_sample, right_sample, block_end, input ready);
    modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

[sv/tblm_level_if.sv]
// Result channel: valid/ready with the per-block band levels, peak and dominant band.
interface tblm_level_if
    import tblm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [LEVEL_W-1:0]   bass_level;
    logic [LEVEL_W-1:0]   mid_level;
    logic [LEVEL_W-1:0]   high_level;
    logic [LEVEL_W-1:0]   peak_level;
    logic [BAND_W-1:0]    dominant_band;

    modport source (output valid, bass_level, mid_level, high_level, peak_level,
                    dominant_band, input ready);
    modport sink   (input valid, bass_level, mid_level, high_level, peak_level,
                    dominant_band, output ready);
endinterface

[sv/tblm_front.sv]
// Front end: channel mode register, frame intake and stereo/mono mixing.
module tblm_front
    import tblm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tblm_frame_if.sink            frame_in,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  fifo_stat_t            q_stat,
    output logic                  q_push,
    output frame_item_t           q_item
);

    logic                       mode_reg;
    logic                       mode_next;
    logic signed [SAMPLE_W:0]   mix_sum;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_CHANNEL_MODE)
                  ? CFG_DATA_W'(mode_reg) : '0;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_CHANNEL_MODE)
        begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // floor((l + r) / 2)
    assign mix_sum = {frame_in.left_sample[SAMPLE_W-1], frame_in.left_sample}
                   + {frame_in.right_sample[SAMPLE_W-1], frame_in.right_sample};

    assign frame_in.ready = !q_stat.full;
    assign q_push         = frame_in.valid && !q_stat.full;
    assign q_item.x       = mode_reg ? mix_sum[SAMPLE_W:1] : frame_in.left_sample;
    assign q_item.last    = frame_in.block_end;

endmodule

[sv/tblm_fifo.sv]
// Short queue between front end and back end.
module tblm_fifo
    import tblm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_item_t push_item,
    input  logic        pop,
    output frame_item_t pop_item,
    output fifo_stat_t  stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/tblm_div.sv]
// Restoring divider, one quotient bit per cycle.
module tblm_div
    import tblm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [DIV_W-1:0]                       dividend,
    input  logic [$clog2(MAX_BLOCK_FRAMES+1)-1:0]  divisor,
    output logic                                   done,
    output logic [DIV_W-1:0]                       quotient
);

    localparam int CW    = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int STEPW = $clog2(DIV_W + 1);

    logic [CW:0]        rem_reg;
    logic [CW:0]        rem_next;
    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W-1:0]   quo_next;
    logic [CW-1:0]      dsr_reg;
    logic [CW-1:0]      dsr_next;
    logic [STEPW-1:0]   step_reg;
    logic [STEPW-1:0]   step_next;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [CW:0]        rem_sh;
    logic               fits;

    assign rem_sh   = {rem_reg[CW-1:0], quo_reg[DIV_W-1]};
    assign fits     = (rem_sh >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEPW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

[sv/tblm_back.sv]
// Back end: filter sequencer, block accumulators, mean computation and result register.
module tblm_back
    import tblm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  fifo_stat_t   q_stat,
    input  frame_item_t  q_item,
    output logic         q_pop,
    tblm_level_if.source level_out
);

    localparam int CW = $clog2(MAX_BLOCK_FRAMES + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_HP      = 6'b000010,
        S_HIGH    = 6'b000100,
        S_ACC     = 6'b001000,
        S_DIVGO   = 6'b010000,
        S_DIVWAIT = 6'b100000
    } back_state_t;

    back_state_t                 state_reg;
    back_state_t                 state_next;
    logic                        emit_reg;
    logic                        emit_next;

    logic signed [SAMPLE_W-1:0]  x_reg;
    logic                        last_reg;
    logic signed [STATE_W-1:0]   bass_st_reg;
    logic signed [STATE_W-1:0]   mid_st_reg;
    logic signed [STATE_W-1:0]   high_st_reg;
    logic signed [STATE_W-1:0]   hp_reg;
    logic [SUM_W-1:0]            bass_sum_reg;
    logic [SUM_W-1:0]            mid_sum_reg;
    logic [SUM_W-1:0]            high_sum_reg;
    logic [LEVEL_W-1:0]          peak_reg;
    logic [CW-1:0]               count_reg;
    logic [BAND_W-1:0]           sel_reg;
    logic [LEVEL_W-1:0]          bass_q_reg;
    logic [LEVEL_W-1:0]          mid_q_reg;
    logic [LEVEL_W-1:0]          high_q_reg;

    logic                        out_valid_reg;
    logic [LEVEL_W-1:0]          out_bass_reg;
    logic [LEVEL_W-1:0]          out_mid_reg;
    logic [LEVEL_W-1:0]          out_high_reg;
    logic [LEVEL_W-1:0]          out_peak_reg;
    logic [BAND_W-1:0]           out_band_reg;

    logic signed [STATE_W-1:0]   x_ext;
    logic signed [STATE_W-1:0]   item_ext;
    logic [SAMPLE_W-1:0]         abs_x;
    logic                        div_start;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quo;
    logic [DIV_W-1:0]            div_dividend;
    logic [SUM_W-1:0]            sel_sum;
    logic                        load_out;
    logic [BAND_W-1:0]           band;

    assign x_ext    = STATE_W'(x_reg);
    assign item_ext = STATE_W'(q_item.x);
    assign abs_x    = x_reg[SAMPLE_W-1] ? SAMPLE_W'(-x_reg) : SAMPLE_W'(x_reg);
    assign q_pop    = (state_reg == S_IDLE) && !emit_reg && !q_stat.empty;
    assign load_out = emit_reg && (!out_valid_reg || level_out.ready);

    always_comb
    begin
        case (sel_reg)
            BAND_BASS: sel_sum = bass_sum_reg;
            BAND_MID:  sel_sum = mid_sum_reg;
            default:   sel_sum = high_sum_reg;
        endcase
    end

    assign div_dividend = {1'b0, sel_sum} + DIV_W'(count_reg >> 1);
    assign div_start    = (state_reg == S_DIVGO);

    always_comb
    begin
        if (bass_sum_reg >= mid_sum_reg && bass_sum_reg >= high_sum_reg)
        begin
            band = BAND_BASS;
        end
        else if (mid_sum_reg >= high_sum_reg)
        begin
            band = BAND_MID;
        end
        else
        begin
            band = BAND_HIGH;
        end
    end

    tblm_div #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_out)
                begin
                    emit_next = 1'b0;
                end
                else if (q_pop)
                begin
                    state_next = S_HP;
                end
            end
            S_HP:      state_next = S_HIGH;
            S_HIGH:    state_next = S_ACC;
            S_ACC:     state_next = last_reg ? S_DIVGO : S_IDLE;
            S_DIVGO:   state_next = S_DIVWAIT;
            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    if (sel_reg == BAND_HIGH)
                    begin
                        state_next = S_IDLE;
                        emit_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DIVGO;
                    end
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            bass_st_reg   <= '0;
            mid_st_reg    <= '0;
            high_st_reg   <= '0;
            bass_sum_reg  <= '0;
            mid_sum_reg   <= '0;
            high_sum_reg  <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
            sel_reg       <= BAND_BASS;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (level_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (q_pop)
            begin
                bass_st_reg <= mul_q15(bass_st_reg, C_BASS_FB) + mul_q15(item_ext, C_BASS_IN);
                mid_st_reg  <= mul_q15(mid_st_reg, C_MID_FB) + mul_q15(item_ext, C_MID_IN);
            end

            if (state_reg == S_HIGH)
            begin
                high_st_reg <= mul_q15(high_st_reg, C_HIGH_FB) + mul_q15(hp_reg, C_HIGH_IN);
            end

            if (state_reg == S_ACC)
            begin
                bass_sum_reg <= sat_add(bass_sum_reg, abs_st(bass_st_reg));
                mid_sum_reg  <= sat_add(mid_sum_reg, abs_st(mid_st_reg));
                high_sum_reg <= sat_add(high_sum_reg, abs_st(high_st_reg));
                if (abs_x > peak_reg)
                begin
                    peak_reg <= abs_x;
                end
                if (count_reg < CW'(MAX_BLOCK_FRAMES))
                begin
                    count_reg <= count_reg + 1'b1;
                end
                sel_reg <= BAND_BASS;
            end
            else if (state_reg == S_DIVWAIT && div_done && sel_reg != BAND_HIGH)
            begin
                sel_reg <= sel_reg + 1'b1;
            end

            if (load_out)
            begin
                bass_sum_reg <= '0;
                mid_sum_reg  <= '0;
                high_sum_reg <= '0;
                peak_reg     <= '0;
                count_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            x_reg    <= q_item.x;
            last_reg <= q_item.last;
        end
        if (state_reg == S_HP)
        begin
            hp_reg <= x_ext - mul_q15(mid_st_reg, C_HP_MID);
        end
        if (state_reg == S_DIVWAIT && div_done)
        begin
            case (sel_reg)
                BAND_BASS: bass_q_reg <= clamp_level(div_quo, FULL_SCALE);
                BAND_MID:  mid_q_reg  <= clamp_level(div_quo, FULL_SCALE);
                default:   high_q_reg <= clamp_level(div_quo, LEVEL_MAX);
            endcase
        end
        if (load_out)
        begin
            out_bass_reg <= bass_q_reg;
            out_mid_reg  <= mid_q_reg;
            out_high_reg <= high_q_reg;
            out_peak_reg <= (peak_reg > FULL_SCALE) ? FULL_SCALE : peak_reg;
            out_band_reg <= band;
        end
    end

    assign level_out.valid         = out_valid_reg;
    assign level_out.bass_level    = out_bass_reg;
    assign level_out.mid_level     = out_mid_reg;
    assign level_out.high_level    = out_high_reg;
    assign level_out.peak_level    = out_peak_reg;
    assign level_out.dominant_band = out_band_reg;

endmodule

[sv/three_band_level_meter_core.sv]
// Top level of the three-band level meter.
//
// frame_in carries one audio frame per transfer (left, right, block_end).
// level_out carries one result per block, on the frame marked block_end:
// mean absolute bass, mid and high filter outputs, the peak sample and the
// dominant band. channel_mode (APB, address 0) selects mono or stereo mix.
//
// Frames pass the filter sequencer one at a time (bass/mid update,
// high-pass tap product, high update, accumulate) before the next is
// taken; a block_end frame stalls it until the block result is loaded.
// A two-entry queue sits between intake and the sequencer.
// After the block_end frame leaves the queue, a result passes the filters,
// the three means via the shared 33-step divider and the result register.
// Reset clears filter states, sums, peak and frame count and sets stereo.
// While level_out stalls, the result holds and the next block keeps
// running; a following result waits until the held one is taken.
module three_band_level_meter_core
    import tblm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tblm_frame_if.sink            frame_in,
    tblm_level_if.source          level_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    fifo_stat_t  q_stat;
    logic        q_push;
    logic        q_pop;
    frame_item_t q_in;
    frame_item_t q_out;

    tblm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    tblm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .stat      (q_stat)
    );

    tblm_back #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_item    (q_out),
        .q_pop     (q_pop),
        .level_out (level_out)
    );

endmodule

[sv/tblm_checker.sv]
// Port-level checks for the three-band level meter, bound to the top level.
module tblm_checker
    import tblm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [LEVEL_W-1:0]  bass_level,
    input logic [LEVEL_W-1:0]  mid_level,
    input logic [LEVEL_W-1:0]  high_level,
    input logic [LEVEL_W-1:0]  peak_level,
    input logic [BAND_W-1:0]   dominant_band,
    input logic                pready
);

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bass_level) && $stable(mid_level)
            && $stable(high_level) && $stable(peak_level) && $stable(dominant_band))
        else $error("stalled result changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bass_level <= FULL_SCALE && mid_level <= FULL_SCALE
            && peak_level <= FULL_SCALE && dominant_band != 2'd3 && pready)
        else $error("result field out of range");

    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (!out_valid) [*8])
        else $error("result valid right after reset");

endmodule

bind three_band_level_meter_core tblm_checker u_tblm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (level_out.valid),
    .out_ready     (level_out.ready),
    .bass_level    (level_out.bass_level),
    .mid_level     (level_out.mid_level),
    .high_level    (level_out.high_level),
    .peak_level    (level_out.peak_level),
    .dominant_band (level_out.dominant_band),
    .pready        (pready)
);

[bench/three_band_level_meter_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for three_band_level_meter_core against a Q15 filter predictor.
module three_band_level_meter_core_test
    import tblm_pkg::*;
();

    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    SETTLE_CYCLES  = 150;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    MAX_FRAMES     = 4096;
    localparam longint FULL_LEVEL    = 32768;
    localparam longint LEVEL_CEIL    = 65535;
    localparam longint SUM_CEIL      = 64'h0000_0000_FFFF_FFFF;

    localparam longint K_BASS_KEEP = 31130;
    localparam longint K_BASS_TAKE = 1638;
    localparam longint K_MID_KEEP  = 26214;
    localparam longint K_MID_TAKE  = 6554;
    localparam longint K_HP_MID    = 22938;
    localparam longint K_HIGH_KEEP = 9830;
    localparam longint K_HIGH_TAKE = 22938;

    localparam logic [CFG_ADDR_W-1:0] ADDR_CHANNEL_MODE = {REG_CHANNEL_MODE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;
    localparam logic                  MODE_MONO         = 1'b0;
    localparam logic                  MODE_STEREO       = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] FS_POS = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] FS_NEG = 16'sh8000;

    typedef enum int {WAVE_NOISE, WAVE_DC, WAVE_SQUARE, WAVE_EXTREME} wave_kind_t;

    typedef struct {
        logic [LEVEL_W-1:0] bass;
        logic [LEVEL_W-1:0] mid;
        logic [LEVEL_W-1:0] high;
        logic [LEVEL_W-1:0] peak;
        logic [BAND_W-1:0]  band;
    } band_levels_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tblm_frame_if frame_if ();
    tblm_level_if level_if ();

    three_band_level_meter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_in  (frame_if),
        .level_out (level_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic                      mix_stereo = MODE_STEREO;
    logic signed [STATE_W-1:0] bass_q     = '0;
    logic signed [STATE_W-1:0] mid_q      = '0;
    logic signed [STATE_W-1:0] high_q     = '0;
    logic [SUM_W-1:0]          bass_acc   = '0;
    logic [SUM_W-1:0]          mid_acc    = '0;
    logic [SUM_W-1:0]          high_acc   = '0;
    logic [LEVEL_W-1:0]        peak_q     = '0;
    int unsigned               frame_total = 0;

    band_levels_t levels_due[$];

    int  mismatches     = 0;
    int  blocks_checked = 0;
    int  frames_mono    = 0;
    int  frames_stereo  = 0;
    int  mode_writes    = 0;
    int  quiet_cycles   = 0;
    int  sink_hold      = 0;
    bit  sender_gaps    = 1'b0;
    bit  sink_stalls    = 1'b0;

    function automatic void note_mismatch(input string what, input longint expv,
                                          input longint actv);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, expv, actv, $realtime);
    endfunction

    function automatic longint q15_scale(input longint v, input longint c);
        return (v * c + 16384) >>> 15;
    endfunction

    function automatic logic [SUM_W-1:0] acc_add(input logic [SUM_W-1:0] s, input longint v);
        longint t;
        t = longint'(s) + ((v < 0) ? -v : v);
        return (t > SUM_CEIL) ? '1 : t[SUM_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] level_mean(input logic [SUM_W-1:0] s,
                                                      input longint cnt, input longint cap);
        longint m;
        m = (longint'(s) + cnt / 2) / cnt;
        if (m > cap)
            m = cap;
        return m[LEVEL_W-1:0];
    endfunction

    // advance the filters by one accepted frame; queue a result on block end
    function automatic void account_frame(input logic signed [SAMPLE_W-1:0] l,
                                          input logic signed [SAMPLE_W-1:0] r,
                                          input logic last);
        longint       x;
        longint       hp;
        longint       ax;
        longint       cnt;
        band_levels_t lv;
        x = mix_stereo ? ((longint'(l) + longint'(r)) >>> 1) : longint'(l);
        if (mix_stereo)
            frames_stereo++;
        else
            frames_mono++;
        ax = (x < 0) ? -x : x;
        if (ax > peak_q)
            peak_q = ax[LEVEL_W-1:0];
        bass_q = STATE_W'(q15_scale(bass_q, K_BASS_KEEP) + q15_scale(x, K_BASS_TAKE));
        mid_q  = STATE_W'(q15_scale(mid_q, K_MID_KEEP) + q15_scale(x, K_MID_TAKE));
        hp     = x - q15_scale(mid_q, K_HP_MID);
        high_q = STATE_W'(q15_scale(high_q, K_HIGH_KEEP) + q15_scale(hp, K_HIGH_TAKE));
        bass_acc = acc_add(bass_acc, bass_q);
        mid_acc  = acc_add(mid_acc, mid_q);
        high_acc = acc_add(high_acc, high_q);
        if (frame_total < MAX_FRAMES)
            frame_total++;
        if (last)
        begin
            cnt     = frame_total;
            lv.bass = level_mean(bass_acc, cnt, FULL_LEVEL);
            lv.mid  = level_mean(mid_acc, cnt, FULL_LEVEL);
            lv.high = level_mean(high_acc, cnt, LEVEL_CEIL);
            lv.peak = (peak_q > FULL_LEVEL) ? LEVEL_W'(FULL_LEVEL) : peak_q;
            if (bass_acc >= mid_acc && bass_acc >= high_acc)
                lv.band = BAND_BASS;
            else if (mid_acc >= high_acc)
                lv.band = BAND_MID;
            else
                lv.band = BAND_HIGH;
            levels_due.insert(levels_due.size(), lv);
            bass_acc    = '0;
            mid_acc     = '0;
            high_acc    = '0;
            peak_q      = '0;
            frame_total = 0;
        end
    endfunction

    always @(posedge clk)
    begin : level_check
        band_levels_t want;
        if (rst_n && level_if.valid && level_if.ready)
        begin
            if (levels_due.size() == 0)
                note_mismatch("unexpected result, bass_level", -1, level_if.bass_level);
            else
            begin
                want = levels_due.pop_front();
                blocks_checked++;
                if (level_if.bass_level !== want.bass)
                    note_mismatch("bass_level", want.bass, level_if.bass_level);
                if (level_if.mid_level !== want.mid)
                    note_mismatch("mid_level", want.mid, level_if.mid_level);
                if (level_if.high_level !== want.high)
                    note_mismatch("high_level", want.high, level_if.high_level);
                if (level_if.peak_level !== want.peak)
                    note_mismatch("peak_level", want.peak, level_if.peak_level);
                if (level_if.dominant_band !== want.band)
                    note_mismatch("dominant_band", want.band, level_if.dominant_band);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((frame_if.valid && frame_if.ready) || (level_if.valid && level_if.ready)
            || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("three_band_level_meter_core verification failed");
            $finish;
        end
    end

    initial
    begin : result_sink
        int stall;
        level_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                level_if.ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            stall = sink_stalls ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                level_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            level_if.ready <= 1'b1;
            @(posedge clk);
            while (!level_if.valid && sink_hold == 0)
                @(posedge clk);
        end
    end

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r, input logic last);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.left_sample  <= l;
        frame_if.right_sample <= r;
        frame_if.block_end    <= last;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        account_frame(l, r, last);
    endtask

    task automatic send_block(input int len, input wave_kind_t kind);
        int                         i;
        int                         base;
        int                         period;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        base   = $urandom_range(0, 64000) - 32000;
        period = $urandom_range(1, 4);
        for (i = 0; i < len; i++)
        begin
            case (kind)
                WAVE_NOISE:  l = SAMPLE_W'($urandom);
                WAVE_DC:     l = SAMPLE_W'(base + $urandom_range(0, 511) - 256);
                WAVE_SQUARE: l = ((i / period) % 2 == 0) ? SAMPLE_W'(base) : SAMPLE_W'(-base);
                default:
                    case ($urandom_range(0, 4))
                        0:       l = FS_POS;
                        1:       l = FS_NEG;
                        2:       l = '0;
                        3:       l = -16'sd1;
                        default: l = 16'sd1;
                    endcase
            endcase
            r = ($urandom_range(0, 2) == 0) ? l : SAMPLE_W'($urandom);
            send_frame(l, r, i == len - 1);
        end
    endtask

    // stop offering frames and let every queued block result come back
    task automatic wait_results_done();
        frame_if.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CHANNEL_MODE)
            mix_stereo = data[0];
        mode_writes++;
        @(posedge clk);
    endtask

    task automatic check_mode_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CHANNEL_MODE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== CFG_DATA_W'(mix_stereo))
            note_mismatch("channel_mode readback", mix_stereo, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_state();
        check_mode_readback();
        // all-zero single-frame block: every sum ties, bass wins
        send_frame('0, '0, 1'b1);
        wait_results_done();
    endtask

    task automatic test_stereo_mix();
        send_frame(FS_POS, FS_POS, 1'b0);
        send_frame(FS_NEG, FS_NEG, 1'b0);
        send_frame(-16'sd1, '0, 1'b0);
        send_frame(16'sd1, '0, 1'b1);
        send_frame(FS_NEG, FS_POS, 1'b0);
        send_frame(FS_POS, FS_NEG, 1'b1);
        wait_results_done();
    endtask

    task automatic test_mono_mix();
        int i;
        reg_write(ADDR_CHANNEL_MODE, 32'hFFFF_FFFE);
        check_mode_readback();
        send_frame(FS_NEG, 16'sd12345, 1'b0);
        send_frame(FS_POS, FS_NEG, 1'b0);
        send_frame('0, FS_POS, 1'b1);
        for (i = 0; i < 7; i++)
            send_frame(i[0] ? FS_NEG : FS_POS, '0, i == 6);
        wait_results_done();
    endtask

    task automatic test_register_writes();
        // mode is mono here; a write to an unmapped address must not touch it
        reg_write(ADDR_UNMAPPED, 32'h0000_0001);
        check_mode_readback();
        send_frame(FS_NEG, FS_POS, 1'b1);
        wait_results_done();
        reg_write(ADDR_CHANNEL_MODE, 32'h0000_0001);
        check_mode_readback();
        send_frame(FS_NEG, FS_NEG, 1'b1);
        wait_results_done();
    endtask

    task automatic test_random_blocks();
        int                    pass_idx;
        int                    sent;
        int                    len;
        logic [CFG_DATA_W-1:0] cfg;
        for (pass_idx = 0; pass_idx < 6; pass_idx++)
        begin
            cfg    = $urandom;
            cfg[0] = pass_idx[0];
            reg_write(ADDR_CHANNEL_MODE, cfg);
            check_mode_readback();
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 270)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160)
                                                  : $urandom_range(1, 24);
                send_block(len, wave_kind_t'($urandom_range(0, 3)));
                sent += len;
            end
            wait_results_done();
        end
    endtask

    task automatic test_result_backpressure();
        int i;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        sink_hold   = HOLD_CYCLES;
        for (i = 0; i < 20; i++)
            send_block(2, wave_kind_t'($urandom_range(0, 3)));
        // sender pauses until every block result is back, then resumes
        wait_results_done();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        for (i = 0; i < 10; i++)
            send_block($urandom_range(1, 6), wave_kind_t'($urandom_range(0, 3)));
        wait_results_done();
    endtask

    // mono full-scale block: negative full scale, then a full-scale square
    task automatic test_full_scale_block();
        int i;
        reg_write(ADDR_CHANNEL_MODE, 32'h0000_0000);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        for (i = 0; i < 60; i++)
            send_frame(FS_NEG, '0, 1'b0);
        for (i = 0; i < 60; i++)
            send_frame(i[0] ? FS_NEG : FS_POS, '0, i == 59);
        wait_results_done();
    endtask

    initial
    begin : run
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        frame_if.valid        <= 1'b0;
        frame_if.left_sample  <= '0;
        frame_if.right_sample <= '0;
        frame_if.block_end    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_stereo_mix();
        test_mono_mix();
        test_register_writes();
        test_random_blocks();
        test_result_backpressure();
        test_full_scale_block();

        if (levels_due.size() != 0)
            note_mismatch("blocks left without a result", 0, levels_due.size());
        $display("covered %0d block results, %0d mono and %0d stereo frames, %0d reg writes",
                 blocks_checked, frames_mono, frames_stereo, mode_writes);
        $display("with a held-off result port, sender pauses and a full-scale block; %0d errors",
                 mismatches);
        if (mismatches == 0)
            $display("three_band_level_meter_core verification clean");
        else
            $display("three_band_level_meter_core verification failed");
        $finish;
    end

endmodule
